// ----- design/rtct_pkg.sv -----
// Package for the region thread count tuner: types, codes and constants.
`default_nettype none
package rtct_pkg;

    typedef enum logic [2:0] {
        PH_REPEAT      = 3'd0,
        PH_S0          = 3'd1,
        PH_S1          = 3'd2,
        PH_S2          = 3'd3,
        PH_END_THREADS = 3'd4,
        PH_END         = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_CMP,
        ST_MISS,
        ST_ENT_RD,
        ST_BEGIN_ANS,
        ST_END_MUL,
        ST_END_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  trial;
        logic [9:0]  best_threads;
        logic [9:0]  prior;
        logic [8:0]  step;
        logic [63:0] best_metric;
        logic [31:0] best_duration;
        logic        best_boost;
        logic [1:0]  entry_metric;
    } t_entry;

    localparam logic [1:0]  MET_TIME    = 2'd0;
    localparam logic [1:0]  MET_ENERGY  = 2'd1;
    localparam logic [1:0]  MET_PRODUCT = 2'd2;

    localparam logic [1:0]  CFG_CORE_COUNT    = 2'd0;
    localparam logic [1:0]  CFG_METRIC_SELECT = 2'd1;
    localparam logic [1:0]  CFG_MIN_BOOST     = 2'd2;

    localparam logic [8:0]  CORE_COUNT_RST = 9'd8;
    localparam logic [1:0]  METRIC_SEL_RST = 2'd0;
    localparam logic [31:0] MIN_BOOST_RST  = 32'd100000;
    localparam logic [9:0]  FIRST_TRIAL    = 10'd2;
    localparam logic [8:0]  MIN_STEP       = 9'd2;

endpackage
`default_nettype wire

// ----- design/region_thread_count_tuner.sv -----
// Top level of the region thread count tuner: sequencer, tables and result register.
//
// A begin item (mode 0) looks up its region key one stored entry per clock through
// the key RAM read port and its single comparator, allocating a fresh entry on a
// miss when the table has room; an end item (mode 1) reads the active entry, forms
// its metric with one 32x32 multiplier and writes back one search step. Input ready
// is high only while no item is being worked on; a result waits in the output
// register while the next item is taken. Key and entry tables are REGIONS-deep RAMs
// with no clearing pass: an entry is initialized when it is allocated.
`default_nettype none
module region_thread_count_tuner
    import rtct_pkg::*;
#(
    parameter int REGIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_region_key,
    input  wire logic [31:0] i_elapsed_time,
    input  wire logic [31:0] i_energy_used,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [9:0]       o_thread_count,
    output logic             o_boost_write,
    output logic             o_boost_value,
    output logic             o_table_full,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(REGIONS);
    localparam int UW = AW + 1;
    localparam int EW = $bits(t_entry);

    t_state         r_state, n_state;
    logic [8:0]     r_core_count;
    logic [1:0]     r_metric_select;
    logic [31:0]    r_min_boost;

    logic           r_mode;
    logic [63:0]    r_key;
    logic [31:0]    r_time, r_energy;
    logic [AW-1:0]  r_idx, n_idx;
    logic [AW-1:0]  r_entry, n_entry;
    logic [UW-1:0]  r_used, n_used;
    logic [AW-1:0]  r_active, n_active;
    logic           r_active_valid, n_active_valid;
    logic [63:0]    r_metric, n_metric;
    logic [9:0]     r_res_threads, n_res_threads;
    logic           r_res_bw, n_res_bw;
    logic           r_res_bv, n_res_bv;
    logic           r_res_full, n_res_full;
    logic           r_out_valid, n_out_valid;
    logic [9:0]     r_thread_count;
    logic           r_boost_write, r_boost_value, r_table_full;
    logic           load_out;
    logic           accept;

    logic           key_we;
    logic [AW-1:0]  key_raddr;
    logic [63:0]    key_rdata;
    logic           ent_we;
    logic [AW-1:0]  ent_waddr;
    t_entry         ent_wdata;
    logic [EW-1:0]  ent_rdata;
    t_entry         ent_rd;
    t_entry         ent_setup;
    t_entry         ent_next;
    logic [63:0]    product;
    logic           boost_due;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign ent_rd  = t_entry'(ent_rdata);
    assign product = {32'd0, r_time} * {32'd0, r_energy};
    assign boost_due = ent_rd.best_duration > r_min_boost;

    always_comb begin
        ent_setup               = '0;
        ent_setup.phase         = PH_REPEAT;
        ent_setup.trial         = {1'b0, r_core_count};
        ent_setup.best_boost    = 1'b1;
        ent_setup.entry_metric  = r_metric_select;
    end

    rtct_ram #(.WIDTH(64), .DEPTH(REGIONS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_used[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    rtct_ram #(.WIDTH(EW), .DEPTH(REGIONS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (EW'(ent_wdata)),
        .i_raddr (r_entry),
        .o_rdata (ent_rdata)
    );

    rtct_step u_step (
        .i_entry      (ent_rd),
        .i_metric     (r_metric),
        .i_time       (r_time),
        .i_core_count (r_core_count),
        .o_entry      (ent_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_core_count    <= CORE_COUNT_RST;
            r_metric_select <= METRIC_SEL_RST;
            r_min_boost     <= MIN_BOOST_RST;
            r_used          <= '0;
            r_active        <= '0;
            r_active_valid  <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_used         <= n_used;
            r_active       <= n_active;
            r_active_valid <= n_active_valid;
            r_out_valid    <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CORE_COUNT:    r_core_count    <= i_cfg_data[8:0];
                    CFG_METRIC_SELECT: r_metric_select <= i_cfg_data[1:0];
                    CFG_MIN_BOOST:     r_min_boost     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_key    <= i_region_key;
            r_time   <= i_elapsed_time;
            r_energy <= i_energy_used;
        end
        r_idx         <= n_idx;
        r_entry       <= n_entry;
        r_metric      <= n_metric;
        r_res_threads <= n_res_threads;
        r_res_bw      <= n_res_bw;
        r_res_bv      <= n_res_bv;
        r_res_full    <= n_res_full;
        if (load_out) begin
            r_thread_count <= r_res_threads;
            r_boost_write  <= r_res_bw;
            r_boost_value  <= r_res_bv;
            r_table_full   <= r_res_full;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_entry        = r_entry;
        n_used         = r_used;
        n_active       = r_active;
        n_active_valid = r_active_valid;
        n_metric       = r_metric;
        n_res_threads  = r_res_threads;
        n_res_bw       = r_res_bw;
        n_res_bv       = r_res_bv;
        n_res_full     = r_res_full;
        key_we         = 1'b0;
        key_raddr      = r_idx + AW'(1);
        ent_we         = 1'b0;
        ent_waddr      = r_entry;
        ent_wdata      = ent_next;
        load_out       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                key_raddr = '0;
                if (accept) begin
                    n_res_threads = '0;
                    n_res_bw      = 1'b0;
                    n_res_bv      = 1'b0;
                    n_res_full    = 1'b0;
                    n_idx         = '0;
                    if (i_mode) begin
                        n_entry = r_active;
                        n_state = r_active_valid ? ST_ENT_RD : ST_DONE;
                    end else begin
                        n_state = (r_used == '0) ? ST_MISS : ST_KEY_CMP;
                    end
                end
            end
            ST_KEY_CMP: begin
                if (key_rdata == r_key) begin
                    n_entry = r_idx;
                    n_state = ST_ENT_RD;
                end else if ({1'b0, r_idx} + UW'(1) == r_used) begin
                    n_state = ST_MISS;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_MISS: begin
                n_res_threads = {1'b0, r_core_count};
                if (r_used == UW'(REGIONS)) begin
                    n_active_valid = 1'b0;
                    n_res_full     = 1'b1;
                end else begin
                    key_we         = 1'b1;
                    ent_we         = 1'b1;
                    ent_waddr      = r_used[AW-1:0];
                    ent_wdata      = ent_setup;
                    n_active       = r_used[AW-1:0];
                    n_active_valid = 1'b1;
                    n_used         = r_used + UW'(1);
                end
                n_state = ST_DONE;
            end
            ST_ENT_RD: begin
                n_state = r_mode ? ST_END_MUL : ST_BEGIN_ANS;
            end
            ST_BEGIN_ANS: begin
                n_active       = r_entry;
                n_active_valid = 1'b1;
                if (ent_rd.phase == PH_END) begin
                    n_res_threads = ent_rd.best_threads;
                end else begin
                    n_res_bw      = boost_due;
                    n_res_bv      = boost_due && ent_rd.best_boost;
                    n_res_threads = (ent_rd.phase == PH_END_THREADS) ?
                                    ent_rd.best_threads : ent_rd.trial;
                end
                n_state = ST_DONE;
            end
            ST_END_MUL: begin
                case (ent_rd.entry_metric)
                    MET_ENERGY:  n_metric = {32'd0, r_energy};
                    MET_PRODUCT: n_metric = product;
                    default:     n_metric = {32'd0, r_time};
                endcase
                n_state = ST_END_UPD;
            end
            ST_END_UPD: begin
                ent_we  = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !i_ready);

    assign o_valid        = r_out_valid;
    assign o_thread_count = r_thread_count;
    assign o_boost_write  = r_boost_write;
    assign o_boost_value  = r_boost_value;
    assign o_table_full   = r_table_full;

endmodule
`default_nettype wire

// ----- design/rtct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rtct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/rtct_step.sv -----
// One step of the per-entry thread count search on an end item.
`default_nettype none
module rtct_step
    import rtct_pkg::*;
(
    input  wire t_entry       i_entry,
    input  wire logic [63:0]  i_metric,
    input  wire logic [31:0]  i_time,
    input  wire logic [8:0]   i_core_count,
    output t_entry            o_entry
);

    logic [10:0] doubled;
    logic [8:0]  half_prior;
    logic [8:0]  half_step;
    logic        better;
    logic        not_worse;

    assign doubled    = {i_entry.trial, 1'b0};
    assign half_prior = i_entry.prior[9:1];
    assign half_step  = {1'b0, i_entry.step[8:1]};
    assign better     = i_metric < i_entry.best_metric;
    assign not_worse  = !(i_entry.best_metric < i_metric);

    always_comb begin
        o_entry = i_entry;
        if (i_entry.phase != PH_END) begin
            if ((i_entry.entry_metric == MET_ENERGY || i_entry.entry_metric == MET_PRODUCT)
                    && i_metric == 64'd0) begin
                o_entry.phase        = PH_REPEAT;
                o_entry.entry_metric = MET_TIME;
            end
            case (o_entry.phase)
                PH_REPEAT: begin
                    o_entry.phase = PH_S0;
                    o_entry.trial = FIRST_TRIAL;
                    o_entry.prior = FIRST_TRIAL;
                end
                PH_S0: begin
                    o_entry.best_metric   = i_metric;
                    o_entry.best_duration = i_time;
                    o_entry.best_threads  = i_entry.trial;
                    o_entry.trial         = doubled[9:0];
                    o_entry.phase         = PH_S1;
                end
                PH_S1: begin
                    if (better) begin
                        o_entry.best_metric   = i_metric;
                        o_entry.best_duration = i_time;
                        o_entry.best_threads  = i_entry.trial;
                        if (doubled <= {2'b00, i_core_count}) begin
                            o_entry.prior = i_entry.trial;
                            o_entry.trial = doubled[9:0];
                        end else begin
                            o_entry.step = half_prior;
                            if (half_prior >= MIN_STEP) begin
                                o_entry.trial = i_entry.trial - {1'b0, half_prior};
                                o_entry.phase = PH_S2;
                            end else begin
                                o_entry.best_boost = 1'b0;
                                o_entry.phase      = PH_END_THREADS;
                            end
                        end
                    end else if (i_entry.best_threads == {2'b00, i_core_count[8:1]}) begin
                        o_entry.best_boost = 1'b0;
                        o_entry.phase      = PH_END_THREADS;
                    end else begin
                        o_entry.step = half_prior;
                        if (half_prior >= MIN_STEP) begin
                            o_entry.trial = i_entry.trial + {1'b0, half_prior};
                            o_entry.phase = PH_S2;
                        end else begin
                            o_entry.best_boost = 1'b0;
                            o_entry.phase      = PH_END_THREADS;
                        end
                    end
                end
                PH_S2: begin
                    if (not_worse) begin
                        o_entry.best_metric   = i_metric;
                        o_entry.best_duration = i_time;
                        o_entry.best_threads  = i_entry.trial;
                    end
                    o_entry.step = half_step;
                    if (half_step >= MIN_STEP) begin
                        o_entry.trial = i_entry.trial + {1'b0, half_step};
                    end else begin
                        o_entry.best_boost = 1'b0;
                        o_entry.phase      = PH_END_THREADS;
                    end
                end
                PH_END_THREADS: begin
                    o_entry.phase = PH_END;
                    if (better) begin
                        o_entry.best_boost = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- design/rtct_checker.sv -----
// Port-level assertions for the region thread count tuner, with its bind.
`default_nettype none
module rtct_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [9:0]  o_thread_count,
    input wire logic        o_boost_write,
    input wire logic        o_boost_value,
    input wire logic        o_table_full
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready stayed high after an item was taken");

    a_full_no_boost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> !o_boost_write)
        else $error("boost write on a full-table result");

    a_value_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_boost_write) |-> !o_boost_value)
        else $error("boost value set without boost write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_thread_count))
        else $error("thread count changed while stalled");

endmodule

bind region_thread_count_tuner rtct_checker u_rtct_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_region_thread_count_tuner.sv -----
// Self-checking testbench for the region thread count tuner: directed table, then random traffic.
module tb_region_thread_count_tuner
    import rtct_pkg::*;
;

    localparam int TABLE_DEPTH     = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PLAN_ROWS       = 26;

    localparam logic       MODE_BEGIN   = 1'b0;
    localparam logic       MODE_END     = 1'b1;
    localparam logic [1:0] MET_TIME_ALT = 2'd3;

    typedef struct packed {
        logic [9:0] threads;
        logic       boost_write;
        logic       boost_value;
        logic       full;
    } t_tuning_answer;

    localparam t_tuning_answer END_ACK = '0;

    typedef struct {
        bit             reload;
        logic           mode;
        logic [63:0]    key;
        logic [31:0]    elapsed;
        logic [31:0]    energy;
        bit             typed;
        t_tuning_answer want;
        logic [8:0]     cores;
        logic [1:0]     metric;
        logic [31:0]    min_boost;
    } t_plan_row;

    localparam logic [8:0]  PHASE_CORES [PHASES] = '{9'd8, 9'd256, 9'd1, 9'd4,
                                                     9'd37, 9'd2, 9'd16, 9'd255};
    localparam logic [1:0]  PHASE_METRIC [PHASES] = '{MET_ENERGY, MET_PRODUCT, MET_TIME,
                                                      MET_TIME_ALT, MET_PRODUCT, MET_ENERGY,
                                                      MET_TIME, MET_PRODUCT};
    localparam logic [31:0] PHASE_MIN_BOOST [PHASES] = '{32'd100000, 32'd0, 32'hFFFF_FFFF,
                                                         32'd250000, 32'd1, 32'd100000,
                                                         32'd150000, 32'd50000};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = MODE_BEGIN;
    logic [63:0] i_region_key = '0;
    logic [31:0] i_elapsed_time = '0;
    logic [31:0] i_energy_used = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_thread_count;
    logic        o_boost_write;
    logic        o_boost_value;
    logic        o_table_full;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_CORE_COUNT;
    logic [31:0] i_cfg_data = '0;

    region_thread_count_tuner #(
        .REGIONS(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_region_key   (i_region_key),
        .i_elapsed_time (i_elapsed_time),
        .i_energy_used  (i_energy_used),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_thread_count (o_thread_count),
        .o_boost_write  (o_boost_write),
        .o_boost_value  (o_boost_value),
        .o_table_full   (o_table_full),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tuner state as predicted
    logic [8:0]     cfg_cores = CORE_COUNT_RST;
    logic [1:0]     cfg_metric = METRIC_SEL_RST;
    logic [31:0]    cfg_min_boost = MIN_BOOST_RST;
    logic [63:0]    region_keys [TABLE_DEPTH];
    t_entry         tune_tab [TABLE_DEPTH];
    int             regions_used = 0;
    int             active_idx = 0;
    bit             active_ok = 1'b0;

    t_tuning_answer answers_due [$];
    int             bad_answers = 0;
    int             cycle_count = 0;
    int             snd_idle = 0;
    int             rcv_stall = 0;
    int             hold_kicks = 0;
    int             hold_taken = 0;
    int             hold_left = 0;
    logic [63:0]    key_pool [24];

    t_plan_row plan [PLAN_ROWS] = '{
        '{0, MODE_END,   64'd0, 32'd5, 32'd7, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
          '{10'd8, 1'b0, 1'b0, 1'b0}, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_END,   64'd0, 32'd1000, 32'd0, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_END,   64'd0, 32'd500000, 32'd1, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_END,   64'd0, 32'd400000, 32'd2, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_END,   64'd0, 32'd450000, 32'd3, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_END,   64'd0, 32'd300000, 32'd4, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1,
          '{10'd8, 1'b0, 1'b0, 1'b0}, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_END,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, END_ACK,
          9'd0, MET_TIME, 32'd0},
        '{1, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd8, MET_PRODUCT, 32'd0},
        '{0, MODE_BEGIN, 64'h5A5A_A5A5_0F0F_F0F0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME,
          32'd0},
        '{0, MODE_END,   64'd0, 32'hFFFF_FFFF, 32'd0, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'h5A5A_A5A5_0F0F_F0F0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME,
          32'd0},
        '{0, MODE_END,   64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{0, MODE_BEGIN, 64'h5A5A_A5A5_0F0F_F0F0, 32'd0, 32'd0, 0, END_ACK, 9'd0, MET_TIME,
          32'd0},
        '{1, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd256, MET_TIME_ALT, 32'hFFFF_FFFF},
        '{0, MODE_BEGIN, 64'd1, 32'd0, 32'd0, 1, '{10'd256, 1'b0, 1'b0, 1'b0}, 9'd0, MET_TIME,
          32'd0},
        '{0, MODE_END,   64'd0, 32'd0, 32'd0, 1, END_ACK, 9'd0, MET_TIME, 32'd0},
        '{1, MODE_BEGIN, 64'd0, 32'd0, 32'd0, 0, END_ACK, 9'd1, MET_ENERGY, 32'd100000},
        '{0, MODE_BEGIN, 64'd2, 32'd0, 32'd0, 1, '{10'd1, 1'b0, 1'b0, 1'b0}, 9'd0, MET_TIME,
          32'd0},
        '{0, MODE_END,   64'd0, 32'd7, 32'd0, 1, END_ACK, 9'd0, MET_TIME, 32'd0}
    };

    function automatic t_entry keep_best(input t_entry x, input logic [63:0] m,
                                         input logic [31:0] t);
        x.best_metric   = m;
        x.best_duration = t;
        x.best_threads  = x.trial;
        return x;
    endfunction

    function automatic t_entry close_threads(input t_entry x);
        x.best_boost = 1'b0;
        x.phase      = PH_END_THREADS;
        return x;
    endfunction

    function automatic t_tuning_answer tune_begin(input logic [63:0] key);
        t_tuning_answer r;
        t_entry         x;
        int             hit;
        int             i;
        r   = '0;
        hit = -1;
        for (i = 0; i < regions_used; i++) begin
            if (hit < 0 && region_keys[i] == key) hit = i;
        end
        if (hit < 0) begin
            if (regions_used >= TABLE_DEPTH) begin
                active_ok = 1'b0;
                r.threads = {1'b0, cfg_cores};
                r.full    = 1'b1;
                return r;
            end
            hit = regions_used;
            region_keys[hit] = key;
            x = '0;
            x.phase        = PH_REPEAT;
            x.trial        = {1'b0, cfg_cores};
            x.best_boost   = 1'b1;
            x.entry_metric = cfg_metric;
            tune_tab[hit]  = x;
            regions_used++;
        end
        active_idx = hit;
        active_ok  = 1'b1;
        x = tune_tab[hit];
        if (x.phase == PH_END) begin
            r.threads = x.best_threads;
            return r;
        end
        if (x.best_duration > cfg_min_boost) begin
            r.boost_write = 1'b1;
            r.boost_value = x.best_boost;
        end
        r.threads = (x.phase == PH_END_THREADS) ? x.best_threads : x.trial;
        return r;
    endfunction

    function automatic void tune_end(input logic [31:0] t, input logic [31:0] en);
        t_entry      x;
        logic [63:0] m;
        int unsigned dbl;
        if (!active_ok) return;
        x = tune_tab[active_idx];
        if (x.phase == PH_END) return;
        case (x.entry_metric)
            MET_ENERGY:  m = {32'd0, en};
            MET_PRODUCT: m = {32'd0, t} * {32'd0, en};
            default:     m = {32'd0, t};
        endcase
        if ((x.entry_metric == MET_ENERGY || x.entry_metric == MET_PRODUCT) && m == 64'd0) begin
            x.phase        = PH_REPEAT;
            x.entry_metric = MET_TIME;
        end
        dbl = 32'(x.trial) * 2;
        case (x.phase)
            PH_REPEAT: begin
                x.phase = PH_S0;
                x.trial = FIRST_TRIAL;
                x.prior = FIRST_TRIAL;
            end
            PH_S0: begin
                x = keep_best(x, m, t);
                x.trial = x.trial << 1;
                x.phase = PH_S1;
            end
            PH_S1: begin
                if (m < x.best_metric) begin
                    x = keep_best(x, m, t);
                    if (dbl <= 32'(cfg_cores)) begin
                        x.prior = x.trial;
                        x.trial = x.trial << 1;
                    end else begin
                        x.step = 9'(x.prior >> 1);
                        if (x.step >= MIN_STEP) begin
                            x.trial = x.trial - 10'(x.step);
                            x.phase = PH_S2;
                        end else begin
                            x = close_threads(x);
                        end
                    end
                end else if (32'(x.best_threads) == 32'(cfg_cores) / 2) begin
                    x = close_threads(x);
                end else begin
                    x.step = 9'(x.prior >> 1);
                    if (x.step >= MIN_STEP) begin
                        x.trial = x.trial + 10'(x.step);
                        x.phase = PH_S2;
                    end else begin
                        x = close_threads(x);
                    end
                end
            end
            PH_S2: begin
                if (!(x.best_metric < m)) x = keep_best(x, m, t);
                x.step = x.step >> 1;
                if (x.step >= MIN_STEP) begin
                    x.trial = x.trial + 10'(x.step);
                end else begin
                    x = close_threads(x);
                end
            end
            PH_END_THREADS: begin
                x.phase = PH_END;
                if (m < x.best_metric) x.best_boost = 1'b0;
            end
            default: begin
            end
        endcase
        tune_tab[active_idx] = x;
    endfunction

    function automatic logic [31:0] draw_measure();
        case ($urandom_range(15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(400000, 1000);
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [63:0] key, input logic [31:0] t,
                             input logic [31:0] en, input bit typed,
                             input t_tuning_answer typed_answer);
        t_tuning_answer r;
        int             gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_region_key   <= key;
        i_elapsed_time <= t;
        i_energy_used  <= en;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (mode == MODE_BEGIN) begin
            r = tune_begin(key);
        end else begin
            tune_end(t, en);
            r = END_ACK;
        end
        answers_due.push_back(typed ? typed_answer : r);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [8:0] cores, input logic [1:0] metric,
                                 input logic [31:0] min_boost);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CORE_COUNT;
        i_cfg_data  <= {23'd0, cores};
        @(posedge i_clk);
        i_cfg_index <= CFG_METRIC_SELECT;
        i_cfg_data  <= {30'd0, metric};
        @(posedge i_clk);
        i_cfg_index <= CFG_MIN_BOOST;
        i_cfg_data  <= min_boost;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cfg_cores     = cores;
        cfg_metric    = metric;
        cfg_min_boost = min_boost;
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_kicks != hold_taken) begin
            hold_taken <= hold_kicks;
            hold_left  <= LONG_HOLD;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_tuning_answer got;
        t_tuning_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_thread_count, o_boost_write, o_boost_value, o_table_full};
            if (answers_due.size() == 0) begin
                bad_answers++;
                if (bad_answers <= 10)
                    $display("unexpected item: threads %0d write %0b value %0b full %0b",
                             got.threads, got.boost_write, got.boost_value, got.full);
            end else begin
                want = answers_due.pop_front();
                if (got.threads !== want.threads || got.boost_write !== want.boost_write ||
                    got.boost_value !== want.boost_value || got.full !== want.full) begin
                    bad_answers++;
                    if (bad_answers <= 10)
                        $display("mismatch: expected threads %0d write %0b value %0b full %0b,",
                                 want.threads, want.boost_write, want.boost_value, want.full,
                                 " got threads %0d write %0b value %0b full %0b",
                                 got.threads, got.boost_write, got.boost_value, got.full);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int          ph;
        int          sent;
        int          pick;
        bit          paused;
        logic [63:0] key;
        logic [31:0] min_boost;
        paused = 1'b0;
        key_pool[0] = 64'd0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[2] = 64'h5A5A_A5A5_0F0F_F0F0;
        key_pool[3] = 64'd1;
        key_pool[4] = 64'd2;
        for (int i = 5; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].reload)
                load_settings(plan[i].cores, plan[i].metric, plan[i].min_boost);
            else
                send_item(plan[i].mode, plan[i].key, plan[i].elapsed, plan[i].energy,
                          plan[i].typed, plan[i].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            min_boost = (ph == 6) ? $urandom : PHASE_MIN_BOOST[ph];
            load_settings(PHASE_CORES[ph], PHASE_METRIC[ph], min_boost);
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 46; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 46; end
                default: begin snd_idle = 32; rcv_stall = 32; end
            endcase
            // hold off the result side while items keep coming
            if (ph == 2) hold_kicks++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (ph == 5 && sent >= 100 && !paused) begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (ph >= 5 && $urandom_range(15) == 0)
                    key = {$urandom, $urandom};
                else
                    key = key_pool[$urandom_range(5 + 2 * ph)];
                if (pick < 80) begin
                    send_item(MODE_BEGIN, key, draw_measure(), draw_measure(), 1'b0, END_ACK);
                    send_item(MODE_END, {$urandom, $urandom}, draw_measure(), draw_measure(),
                              1'b0, END_ACK);
                    sent += 2;
                end else begin
                    send_item(pick < 90 ? MODE_BEGIN : MODE_END, key, draw_measure(),
                              draw_measure(), 1'b0, END_ACK);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (bad_answers == 0 && answers_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
